// ===== rtl/core/smms_pkg.sv =====
// shared types and constants for the run statistics block
`timescale 1ns / 1ps
package smms_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 17;
    localparam int INDEX_W  = 16;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 64;
    localparam int PROD_W   = 48;
    localparam int WIDE_W   = 80;
    localparam int DEN_W    = 32;
    localparam int ROOT_W   = 64;
    localparam int STD_W    = 23;
    localparam int STEP_W   = 7;

    localparam int MUL_STEPS  = 40;
    localparam int DIV_STEPS  = 80;
    localparam int ROOT_STEPS = 40;

    localparam logic [STD_W-1:0]  STD_MAX  = 23'h7F_FFFF;
    localparam logic [ROOT_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_smms_in;

    typedef struct packed {
        logic        [COUNT_W-1:0]  sample_count;
        logic signed [SAMPLE_W-1:0] min_value;
        logic        [INDEX_W-1:0]  min_position;
        logic signed [SAMPLE_W-1:0] max_value;
        logic        [INDEX_W-1:0]  max_position;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic        [STD_W-1:0]    std_dev;
        logic                       overflowed;
    } t_smms_out;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_PREP,
        ST_MUL_N,
        ST_MUL_LD,
        ST_MUL_S,
        ST_DIV_LD,
        ST_DIV,
        ST_ROOT_LD,
        ST_ROOT,
        ST_OUT
    } t_smms_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PREP,
        OP_MUL,
        OP_MUL_LD,
        OP_DIV_LD,
        OP_DIV,
        OP_ROOT_LD,
        OP_ROOT,
        OP_LOAD_OUT
    } t_smms_op;

    typedef struct packed {
        logic     in_ready;
        t_smms_op op;
    } t_smms_cmd;

    typedef struct packed {
        logic last_beat;
        logic out_free;
    } t_smms_stat;

endpackage

// ===== rtl/core/smms_ctrl.sv =====
// sequencer for accumulation and the end-of-run arithmetic
`timescale 1ns / 1ps
module smms_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smms_pkg::t_smms_stat  i_stat,
    output smms_pkg::t_smms_cmd   o_cmd
);
    import smms_pkg::*;

    t_smms_state        r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            ST_ACCUM: begin
                if (i_stat.last_beat) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:   n_state = ST_PREP;
            ST_PREP:    n_state = ST_MUL_N;
            ST_MUL_N: begin
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = ST_MUL_LD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MUL_LD:  n_state = ST_MUL_S;
            ST_MUL_S: begin
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = ST_DIV_LD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIV_LD:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ROOT_LD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ROOT_LD: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default:    n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = OP_NONE;
        case (r_state)
            ST_ACCUM:   o_cmd.in_ready = 1'b1;
            ST_PREP:    o_cmd.op = OP_PREP;
            ST_MUL_N:   o_cmd.op = OP_MUL;
            ST_MUL_LD:  o_cmd.op = OP_MUL_LD;
            ST_MUL_S:   o_cmd.op = OP_MUL;
            ST_DIV_LD:  o_cmd.op = OP_DIV_LD;
            ST_DIV:     o_cmd.op = OP_DIV;
            ST_ROOT_LD: o_cmd.op = OP_ROOT_LD;
            ST_ROOT:    o_cmd.op = OP_ROOT;
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                end
            end
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/smms_dp.sv =====
// accumulators, shift-add multiplier, restoring divider, square root and result register
`timescale 1ns / 1ps
module smms_dp #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  smms_pkg::t_smms_in    i_in,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output smms_pkg::t_smms_out   o_out,
    input  smms_pkg::t_smms_cmd   i_cmd,
    output smms_pkg::t_smms_stat  o_stat
);
    import smms_pkg::*;

    localparam int                 EXT_SHIFT = SAMPLE_W - SAMPLE_BITS;
    localparam logic [COUNT_W-1:0] CAPACITY  = COUNT_W'(MAX_SAMPLES);

    logic                       w_accept;
    logic signed [SAMPLE_W-1:0] w_shl;
    logic signed [SAMPLE_W-1:0] w_ext;
    logic signed [PROD_W-1:0]   w_square;

    // input stage
    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic        [PROD_W-1:0]   r_a_square;

    // run state
    logic        [COUNT_W-1:0]  r_count;
    logic signed [SAMPLE_W-1:0] r_min;
    logic        [INDEX_W-1:0]  r_min_idx;
    logic signed [SAMPLE_W-1:0] r_max;
    logic        [INDEX_W-1:0]  r_max_idx;
    logic signed [SUM_W-1:0]    r_sum;
    logic        [SQ_W-1:0]     r_sumsq;
    logic                       r_dropped;

    logic                       w_room;
    logic                       w_new_min;
    logic                       w_new_max;

    // finishing datapath
    logic        [SUM_W-1:0]    w_mag;
    logic        [2*COUNT_W-1:0] w_pair;
    logic        [SUM_W-1:0]    r_mag;
    logic                       r_neg;
    logic        [DEN_W-1:0]    r_den_var;
    logic        [WIDE_W-1:0]   r_ma;
    logic        [SUM_W-1:0]    r_mb;
    logic        [WIDE_W-1:0]   r_acc;
    logic        [WIDE_W-1:0]   r_nsq;
    logic        [WIDE_W-1:0]   r_num;
    logic        [DEN_W-1:0]    r_den;
    logic        [DEN_W-1:0]    r_rem;
    logic                       r_var_zero;
    logic        [DEN_W:0]      w_rem_sh;
    logic        [DEN_W:0]      w_rem_sub;
    logic                       w_rem_ge;
    logic        [ROOT_W-1:0]   r_rv;
    logic        [ROOT_W-1:0]   r_res;
    logic        [ROOT_W-1:0]   r_bit;
    logic        [ROOT_W-1:0]   w_trial;
    logic                       w_fit;
    logic        [SUM_W-1:0]    w_mean_full;
    logic        [STD_W-1:0]    w_std;

    // result register
    logic                       r_out_valid;
    t_smms_out                  r_out;

    assign w_accept = i_in_valid && i_cmd.in_ready;
    assign w_shl    = i_in.sample <<< EXT_SHIFT;
    assign w_ext    = w_shl >>> EXT_SHIFT;
    assign w_square = w_ext * w_ext;

    assign o_stat.last_beat = w_accept && i_in.last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_sample <= w_ext;
            r_a_square <= $unsigned(w_square);
        end
    end

    assign w_room    = r_count < CAPACITY;
    assign w_new_min = (r_count == '0) || (r_a_sample <= r_min);
    assign w_new_max = (r_count == '0) || (r_a_sample >= r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_min     <= '0;
            r_min_idx <= '0;
            r_max     <= '0;
            r_max_idx <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_OUT) begin
            r_count   <= '0;
            r_min     <= '0;
            r_min_idx <= '0;
            r_max     <= '0;
            r_max_idx <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_dropped <= 1'b0;
        end else if (r_a_valid) begin
            if (w_room) begin
                if (w_new_min) begin
                    r_min     <= r_a_sample;
                    r_min_idx <= r_count[INDEX_W-1:0];
                end
                if (w_new_max) begin
                    r_max     <= r_a_sample;
                    r_max_idx <= r_count[INDEX_W-1:0];
                end
                r_sum   <= r_sum + SUM_W'(r_a_sample);
                r_sumsq <= r_sumsq + SQ_W'(r_a_square);
                r_count <= r_count + 1'b1;
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    assign w_mag  = r_sum[SUM_W-1] ? (SUM_W'(0) - $unsigned(r_sum)) : $unsigned(r_sum);
    assign w_pair = (2*COUNT_W)'(r_count) * (2*COUNT_W)'(r_count - 1'b1);

    assign w_rem_sh  = {r_rem, r_num[WIDE_W-1]};
    assign w_rem_ge  = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    assign w_trial = r_res + r_bit;
    assign w_fit   = r_rv >= w_trial;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_PREP: begin
                r_mag     <= w_mag;
                r_neg     <= r_sum[SUM_W-1];
                r_den_var <= w_pair[DEN_W-1:0];
                r_ma      <= WIDE_W'(r_sumsq);
                r_mb      <= SUM_W'(r_count);
                r_acc     <= '0;
            end
            OP_MUL: begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            OP_MUL_LD: begin
                r_nsq <= r_acc;
                r_ma  <= WIDE_W'(r_mag);
                r_mb  <= r_mag;
                r_acc <= '0;
            end
            OP_DIV_LD: begin
                r_num      <= r_nsq - r_acc;
                r_var_zero <= (r_count < COUNT_W'(2)) || (r_nsq <= r_acc);
                r_den      <= r_den_var;
                r_rem      <= '0;
            end
            OP_DIV: begin
                r_rem <= w_rem_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_num <= {r_num[WIDE_W-2:0], w_rem_ge};
            end
            OP_ROOT_LD: begin
                r_rv  <= r_num[ROOT_W-1:0];
                r_res <= '0;
                r_bit <= SQRT_TOP;
                r_num <= {r_mag, {(WIDE_W-SUM_W){1'b0}}};
                r_den <= DEN_W'(r_count);
                r_rem <= '0;
            end
            OP_ROOT: begin
                r_rem <= w_rem_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_num <= {r_num[WIDE_W-2:0], w_rem_ge};
                if (r_bit != '0) begin
                    if (w_fit) begin
                        r_rv  <= r_rv - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_mean_full = r_neg ? (SUM_W'(0) - r_num[SUM_W-1:0]) : r_num[SUM_W-1:0];

    always_comb begin
        if (r_var_zero) begin
            w_std = '0;
        end else if (r_res > ROOT_W'(STD_MAX)) begin
            w_std = STD_MAX;
        end else begin
            w_std = r_res[STD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_OUT) begin
            r_out.sample_count <= r_count;
            r_out.min_value    <= r_min;
            r_out.min_position <= r_min_idx;
            r_out.max_value    <= r_max;
            r_out.max_position <= r_max_idx;
            r_out.mean_value   <= $signed(w_mean_full[SAMPLE_W-1:0]);
            r_out.std_dev      <= w_std;
            r_out.overflowed   <= r_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/stream_min_max_mean_std.sv =====
// top level of the streaming run statistics block
`timescale 1ns / 1ps
// Takes signed Q12.12 samples one beat per cycle and, on the beat flagged last,
// returns one result beat with count, min and max with their latest positions,
// mean truncated toward zero and the floored sample standard deviation. Samples
// past MAX_SAMPLES are dropped and the result is flagged. While a run streams in,
// input ready stays high. After the last beat the input closes for a drain and
// a setup state, two 40-step shift-add multiplies for n*sum_sq and sum^2, an
// 80-step restoring divide by n*(n-1), then a 40-step pass that runs the mean
// divide alongside a 32-step square root, with a load state ahead of each of the
// second multiply, the divide and that pass, and a final state that loads the
// result register. If the previous result has not been taken by then, the block
// holds until it is. The result register lets the next run start while a
// finished result still waits on the output.
module stream_min_max_mean_std #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  smms_pkg::t_smms_in   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output smms_pkg::t_smms_out  o_out
);
    import smms_pkg::*;

    t_smms_cmd  w_cmd;
    t_smms_stat w_stat;

    smms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    smms_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    assign o_in_ready = w_cmd.in_ready;

endmodule

// ===== sim/tb_stream_min_max_mean_std.sv =====
// self-checking testbench for the streaming run statistics block
`timescale 1ns / 1ps
module tb_stream_min_max_mean_std;
    import smms_pkg::*;

    localparam int MAX_SAMPLES  = 65536;
    localparam int SAMPLE_BITS  = 24;
    localparam int SIGN_SHIFT   = SAMPLE_W - SAMPLE_BITS;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 5_000_000;

    localparam logic signed [SAMPLE_W-1:0] MOST_POS = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 24'sh80_0000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_smms_in  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_smms_out out_beat;

    stream_min_max_mean_std #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    int unsigned cycle_count = 0;
    int          error_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** stream_min_max_mean_std: FAILED **");
            $finish;
        end
    end

    // running statistics of the open run
    int unsigned                acc_count   = 0;
    logic signed [SAMPLE_W-1:0] acc_min     = '0;
    logic        [INDEX_W-1:0]  acc_min_pos = '0;
    logic signed [SAMPLE_W-1:0] acc_max     = '0;
    logic        [INDEX_W-1:0]  acc_max_pos = '0;
    longint signed              acc_sum     = 0;
    logic        [63:0]         acc_sumsq   = '0;
    logic                       acc_dropped = 1'b0;

    t_smms_out pending_stats[$];

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [STD_W-1:0] floor_std_dev(input int unsigned n,
                                                       input longint signed sum,
                                                       input logic [63:0] sumsq);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] den;
        logic [127:0] quot;
        logic [63:0]  mag;
        logic [63:0]  root;
        if (n < 2) return '0;
        lhs  = 128'(n) * 128'(sumsq);
        mag  = (sum < 0) ? 64'(-sum) : 64'(sum);
        rhs  = 128'(mag) * 128'(mag);
        if (lhs <= rhs) return '0;
        den  = 128'(n) * 128'(n - 1);
        quot = (lhs - rhs) / den;
        root = floor_root(quot[63:0]);
        return (root > 64'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
    endfunction

    task automatic fold_sample(input t_smms_in beat);
        logic signed [SAMPLE_W-1:0] s;
        longint signed              wide_s;
        t_smms_out                  res;
        s = beat.sample <<< SIGN_SHIFT;
        s = s >>> SIGN_SHIFT;
        wide_s = s;
        if (acc_count < MAX_SAMPLES) begin
            if (acc_count == 0 || s <= acc_min) begin
                acc_min     = s;
                acc_min_pos = INDEX_W'(acc_count);
            end
            if (acc_count == 0 || s >= acc_max) begin
                acc_max     = s;
                acc_max_pos = INDEX_W'(acc_count);
            end
            acc_sum   = acc_sum + wide_s;
            acc_sumsq = acc_sumsq + 64'(wide_s * wide_s);
            acc_count = acc_count + 1;
        end else begin
            acc_dropped = 1'b1;
        end
        if (beat.last) begin
            res.sample_count = COUNT_W'(acc_count);
            res.min_value    = acc_min;
            res.min_position = acc_min_pos;
            res.max_value    = acc_max;
            res.max_position = acc_max_pos;
            res.mean_value   = SAMPLE_W'(acc_sum / longint'(acc_count));
            res.std_dev      = floor_std_dev(acc_count, acc_sum, acc_sumsq);
            res.overflowed   = acc_dropped;
            pending_stats.push_back(res);
            acc_count   = 0;
            acc_min     = '0;
            acc_min_pos = '0;
            acc_max     = '0;
            acc_max_pos = '0;
            acc_sum     = 0;
            acc_sumsq   = '0;
            acc_dropped = 1'b0;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) fold_sample(in_beat);
    end

    always @(posedge clk) begin : result_check
        t_smms_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_stats.size() == 0) begin
                $error("result beat with no run closed");
                error_count++;
            end else begin
                want = pending_stats.pop_front();
                if (out_beat.sample_count !== want.sample_count) begin
                    $error("sample_count expected %0d got %0d",
                           want.sample_count, out_beat.sample_count);
                    error_count++;
                end
                if (out_beat.min_value !== want.min_value) begin
                    $error("min_value expected %0d got %0d", want.min_value, out_beat.min_value);
                    error_count++;
                end
                if (out_beat.min_position !== want.min_position) begin
                    $error("min_position expected %0d got %0d",
                           want.min_position, out_beat.min_position);
                    error_count++;
                end
                if (out_beat.max_value !== want.max_value) begin
                    $error("max_value expected %0d got %0d", want.max_value, out_beat.max_value);
                    error_count++;
                end
                if (out_beat.max_position !== want.max_position) begin
                    $error("max_position expected %0d got %0d",
                           want.max_position, out_beat.max_position);
                    error_count++;
                end
                if (out_beat.mean_value !== want.mean_value) begin
                    $error("mean_value expected %0d got %0d",
                           want.mean_value, out_beat.mean_value);
                    error_count++;
                end
                if (out_beat.std_dev !== want.std_dev) begin
                    $error("std_dev expected %0d got %0d", want.std_dev, out_beat.std_dev);
                    error_count++;
                end
                if (out_beat.overflowed !== want.overflowed) begin
                    $error("overflowed expected %0d got %0d",
                           want.overflowed, out_beat.overflowed);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern in one of three randomly chosen modes
    int unsigned rx_mode   = 0;
    int unsigned hold_left = 0;

    always @(posedge clk) begin
        if (cycle_count[9:0] == 10'd0) rx_mode <= $urandom_range(0, 2);
        if (!rst_n) begin
            out_ready <= 1'b1;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            case (rx_mode)
                0: begin
                    out_ready <= 1'b1;
                    hold_left <= $urandom_range(0, 40);
                end
                1: begin
                    out_ready <= ($urandom_range(0, 3) != 0);
                    hold_left <= 0;
                end
                default: begin
                    out_ready <= ~out_ready;
                    hold_left <= out_ready ? $urandom_range(1, 300) : $urandom_range(0, 10);
                end
            endcase
        end
    end

    // sender side
    bit                         gaps_enabled = 1'b1;
    bit                         valid_held   = 1'b0;
    int                         burst_left   = 4;
    logic signed [SAMPLE_W-1:0] last_random  = '0;

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int gap;
        in_valid <= 1'b1;
        in_beat  <= '{sample: s, last: l};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (gaps_enabled && burst_left <= 0) begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 250) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end else begin
            valid_held = 1'b1;
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 5))
            0, 1: s = SAMPLE_W'($urandom);
            2: begin
                s = SAMPLE_W'($urandom_range(0, 64));
                s = s - 24'sd32;
            end
            3: s = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
            4: s = last_random;
            default: begin
                s = SAMPLE_W'($urandom_range(0, 16));
                s = last_random + s - 24'sd8;
            end
        endcase
        last_random = s;
        return s;
    endfunction

    task automatic test_single_sample_runs();
        send_beat(24'sd0, 1'b1);
        send_beat(MOST_POS, 1'b1);
        send_beat(MOST_NEG, 1'b1);
    endtask

    task automatic test_extreme_spread();
        // deviation saturates
        send_beat(MOST_NEG, 1'b0);
        send_beat(MOST_POS, 1'b1);
        send_beat(MOST_POS, 1'b0);
        send_beat(MOST_NEG, 1'b0);
        send_beat(MOST_POS, 1'b0);
        send_beat(MOST_NEG, 1'b1);
    endtask

    task automatic test_tie_positions();
        repeat (3) send_beat(24'sd5, 1'b0);
        send_beat(24'sd5, 1'b1);
        send_beat(24'sd3, 1'b0);
        send_beat(-24'sd2, 1'b0);
        send_beat(24'sd7, 1'b0);
        send_beat(-24'sd2, 1'b0);
        send_beat(24'sd7, 1'b0);
        send_beat(24'sd1, 1'b1);
    endtask

    task automatic test_mean_truncation();
        send_beat(24'sd1, 1'b0);
        send_beat(24'sd2, 1'b0);
        send_beat(24'sd3, 1'b1);
        send_beat(-24'sd1, 1'b0);
        send_beat(-24'sd2, 1'b1);
    endtask

    task automatic test_random_runs();
        int sent;
        int run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
            gaps_enabled = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < run_len; i++) begin
                send_beat(random_sample(), i == run_len - 1);
                sent++;
            end
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample_runs();
        test_extreme_spread();
        test_tie_positions();
        test_mean_truncation();
        test_random_runs();

        if (valid_held) in_valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("** stream_min_max_mean_std: PASSED **");
        end else begin
            $display("** stream_min_max_mean_std: FAILED **");
        end
        $finish;
    end

endmodule
